/* sv/rfpd_pkg.sv */
// ----------------------------------------------------------------------------
// rfpd_pkg
// shared types, constants and the control program of the rounded
// fixed-point divider
// ----------------------------------------------------------------------------
package rfpd_pkg;

    localparam int DATA_WIDTH_DEF  = 64;
    localparam int SCALE_WIDTH_DEF = 32;
    localparam int NUM_PORT_W      = 64;
    localparam int SCALE_PORT_W    = 32;
    localparam int SCALE_RESET     = 1000 * 1000;

    // payload types
    typedef struct packed {
        logic [NUM_PORT_W-1:0] numerator;
        logic [NUM_PORT_W-1:0] denominator;
    } t_in_item;

    typedef struct packed {
        logic [NUM_PORT_W-1:0]   integer_part;
        logic [SCALE_PORT_W-1:0] fraction_part;
        logic                    divide_by_zero;
    } t_out_item;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP       = 4'd0;
    localparam t_op OP_LOAD      = 4'd1;
    localparam t_op OP_DIV       = 4'd2;
    localparam t_op OP_FINIT     = 4'd3;
    localparam t_op OP_DBL       = 4'd4;
    localparam t_op OP_ADD       = 4'd5;
    localparam t_op OP_ROUND     = 4'd6;
    localparam t_op OP_CARRY     = 4'd7;
    localparam t_op OP_EMIT      = 4'd8;
    localparam t_op OP_EMIT_ZERO = 4'd9;

    // jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_NONE       = 3'd0;
    localparam t_cond C_ALWAYS     = 3'd1;
    localparam t_cond C_NO_START   = 3'd2;
    localparam t_cond C_DEN_ZERO   = 3'd3;
    localparam t_cond C_CNT_MORE   = 3'd4;
    localparam t_cond C_SCALE_ZERO = 3'd5;

    // program steps
    typedef logic [3:0] t_step;
    localparam t_step S_IDLE   = 4'd0;
    localparam t_step S_CHECK  = 4'd1;
    localparam t_step S_DIV    = 4'd2;
    localparam t_step S_FINIT  = 4'd3;
    localparam t_step S_DBL    = 4'd4;
    localparam t_step S_ADD    = 4'd5;
    localparam t_step S_ROUND  = 4'd6;
    localparam t_step S_CARRY  = 4'd7;
    localparam t_step S_FINISH = 4'd8;
    localparam t_step S_ZERO   = 4'd9;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // status from datapath to sequencer
    typedef struct packed {
        logic den_zero;
        logic cnt_more;
        logic scale_zero;
    } t_flags;

    function automatic t_uword uword(input t_op op, input t_cond cond, input t_step target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store
    function automatic t_uword program_rom(input t_step pc);
        t_uword w;
        unique case (pc)
            S_IDLE:   w = uword(OP_LOAD,      C_NO_START,   S_IDLE);
            S_CHECK:  w = uword(OP_NOP,       C_DEN_ZERO,   S_ZERO);
            S_DIV:    w = uword(OP_DIV,       C_CNT_MORE,   S_DIV);
            S_FINIT:  w = uword(OP_FINIT,     C_SCALE_ZERO, S_FINISH);
            S_DBL:    w = uword(OP_DBL,       C_NONE,       S_IDLE);
            S_ADD:    w = uword(OP_ADD,       C_CNT_MORE,   S_DBL);
            S_ROUND:  w = uword(OP_ROUND,     C_NONE,       S_IDLE);
            S_CARRY:  w = uword(OP_CARRY,     C_NONE,       S_IDLE);
            S_FINISH: w = uword(OP_EMIT,      C_ALWAYS,     S_IDLE);
            S_ZERO:   w = uword(OP_EMIT_ZERO, C_ALWAYS,     S_IDLE);
            default:  w = uword(OP_NOP,       C_ALWAYS,     S_IDLE);
        endcase
        return w;
    endfunction

endpackage

/* sv/rfpd_seq.sv */
// ----------------------------------------------------------------------------
// rfpd_seq
// step counter and control store; issues one operation per cycle
// ----------------------------------------------------------------------------
module rfpd_seq
    import rfpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_flags i_flags,
    output t_op    o_op,
    output logic   o_busy
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_uw;
    logic   w_jump;

    assign w_uw = program_rom(r_pc);

    always_comb begin
        unique case (w_uw.cond)
            C_NONE:       w_jump = 1'b0;
            C_ALWAYS:     w_jump = 1'b1;
            C_NO_START:   w_jump = !i_start;
            C_DEN_ZERO:   w_jump = i_flags.den_zero;
            C_CNT_MORE:   w_jump = i_flags.cnt_more;
            C_SCALE_ZERO: w_jump = i_flags.scale_zero;
            default:      w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + 4'd1;
    end

    // load only when an item is really taken
    assign o_op   = (w_uw.op == OP_LOAD && !i_start) ? OP_NOP : w_uw.op;
    assign o_busy = (r_pc != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* sv/rfpd_dp.sv */
// ----------------------------------------------------------------------------
// rfpd_dp
// datapath: restoring divider, modular double-and-add unit, rounding
// ----------------------------------------------------------------------------
module rfpd_dp
    import rfpd_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int SCALE_WIDTH = SCALE_WIDTH_DEF
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op                    i_op,
    input  t_in_item               i_item,
    input  logic [SCALE_WIDTH-1:0] i_scale,
    output t_flags                 o_flags,
    output t_out_item              o_result,
    output logic                   o_valid
);

    localparam int MAX_W = (DATA_WIDTH > SCALE_WIDTH) ? DATA_WIDTH : SCALE_WIDTH;
    localparam int CNT_W = $clog2(MAX_W + 1);

    logic [DATA_WIDTH-1:0]  r_quo;
    logic [DATA_WIDTH-1:0]  r_rem;
    logic [DATA_WIDTH-1:0]  r_den;
    logic [DATA_WIDTH-1:0]  r_left;
    logic [SCALE_WIDTH-1:0] r_frac;
    logic [SCALE_WIDTH-1:0] r_sbits;
    logic [CNT_W-1:0]       r_cnt;
    t_out_item              r_result;
    logic                   r_valid;

    // divider step
    logic [DATA_WIDTH:0]    w_shift;
    logic [DATA_WIDTH:0]    w_sub;
    logic                   w_ge;

    // modular adder shared by double and add steps
    logic [DATA_WIDTH-1:0]  w_addend;
    logic [DATA_WIDTH:0]    w_sum;
    logic                   w_wrap;
    logic [DATA_WIDTH:0]    w_mod;
    logic                   w_round_up;

    assign w_shift = {r_rem, r_quo[DATA_WIDTH-1]};
    assign w_sub   = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    assign w_addend   = (i_op == OP_DBL) ? r_left : r_rem;
    assign w_sum      = {1'b0, r_left} + {1'b0, w_addend};
    assign w_wrap     = (w_sum >= {1'b0, r_den});
    assign w_mod      = w_wrap ? (w_sum - {1'b0, r_den}) : w_sum;
    assign w_round_up = ({r_left, 1'b0} >= {1'b0, r_den});

    assign o_flags.den_zero   = (r_den == '0);
    assign o_flags.cnt_more   = (r_cnt != CNT_W'(1));
    assign o_flags.scale_zero = (i_scale == '0);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_quo  <= DATA_WIDTH'(i_item.numerator);
                r_den  <= DATA_WIDTH'(i_item.denominator);
                r_rem  <= '0;
                r_frac <= '0;
                r_cnt  <= CNT_W'(DATA_WIDTH);
            end
            OP_DIV: begin
                r_rem <= w_ge ? w_sub[DATA_WIDTH-1:0] : w_shift[DATA_WIDTH-1:0];
                r_quo <= {r_quo[DATA_WIDTH-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_FINIT: begin
                r_left  <= '0;
                r_frac  <= '0;
                r_sbits <= i_scale;
                r_cnt   <= CNT_W'(SCALE_WIDTH);
            end
            OP_DBL: begin
                r_left <= w_mod[DATA_WIDTH-1:0];
                r_frac <= {r_frac[SCALE_WIDTH-2:0], w_wrap};
            end
            OP_ADD: begin
                if (r_sbits[SCALE_WIDTH-1]) begin
                    r_left <= w_mod[DATA_WIDTH-1:0];
                    r_frac <= r_frac + SCALE_WIDTH'(w_wrap);
                end
                r_sbits <= {r_sbits[SCALE_WIDTH-2:0], 1'b0};
                r_cnt   <= r_cnt - CNT_W'(1);
            end
            OP_ROUND: begin
                if (w_round_up) begin
                    r_frac <= r_frac + SCALE_WIDTH'(1);
                end
            end
            OP_CARRY: begin
                if (r_frac == i_scale) begin
                    r_quo  <= r_quo + DATA_WIDTH'(1);
                    r_frac <= '0;
                end
            end
            OP_EMIT: begin
                r_result.integer_part   <= NUM_PORT_W'(r_quo);
                r_result.fraction_part  <= SCALE_PORT_W'(r_frac);
                r_result.divide_by_zero <= 1'b0;
            end
            OP_EMIT_ZERO: begin
                r_result.integer_part   <= '0;
                r_result.fraction_part  <= '0;
                r_result.divide_by_zero <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_op == OP_EMIT) || (i_op == OP_EMIT_ZERO);
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_valid;

endmodule

/* sv/rounded_fixed_point_divider.sv */
// ----------------------------------------------------------------------------
// rounded_fixed_point_divider
// unsigned division giving an integer quotient and a fraction rounded half
// up in units of a programmable scale
// ----------------------------------------------------------------------------
// usage
//   input channel: present an item on i_item and raise start; the item is
//   taken at a clock edge where start is high and busy is low
//   result channel: o_valid is high for exactly one cycle with o_result;
//   the receiver takes it then, it cannot hold results off
//   config: i_cfg_we writes i_cfg_data into the fraction scale; write it
//   only while busy is low and no result is pending
// latency / throughput
//   a microcoded sequencer runs a bit-serial restoring divide (one quotient
//   bit per cycle) and then a modular double-and-add over the scale bits
//   (two cycles per bit) through one shared adder/compare unit
//   busy is high for DATA_WIDTH + 2*SCALE_WIDTH + 5 cycles, 133 by default;
//   the strobe follows in the next cycle, in which a new item may be taken,
//   so one item every DATA_WIDTH + 2*SCALE_WIDTH + 6 cycles (134)
//   zero scale skips the fraction loop; zero denominator: 2 busy cycles
// reset
//   synchronous active low; the sequencer returns to idle, the strobe
//   drops and the scale returns to one million
// ----------------------------------------------------------------------------
module rounded_fixed_point_divider
    import rfpd_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int SCALE_WIDTH = SCALE_WIDTH_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // item input
    input  logic                    start,
    output logic                    busy,
    input  t_in_item                i_item,
    // result output
    output logic                    o_valid,
    output t_out_item               o_result,
    // scale register
    input  logic                    i_cfg_we,
    input  logic [SCALE_PORT_W-1:0] i_cfg_data
);

    logic [SCALE_WIDTH-1:0] r_scale;
    t_op                    w_op;
    t_flags                 w_flags;
    logic                   w_busy;

    // scale register, taken modulo the scale width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_WIDTH'(64'(SCALE_RESET));
        end else if (i_cfg_we) begin
            r_scale <= SCALE_WIDTH'(64'(i_cfg_data));
        end
    end

    // program counter and control store
    rfpd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (w_flags),
        .o_op    (w_op),
        .o_busy  (w_busy)
    );

    // arithmetic datapath and result register
    rfpd_dp #(
        .DATA_WIDTH  (DATA_WIDTH),
        .SCALE_WIDTH (SCALE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_item   (i_item),
        .i_scale  (r_scale),
        .o_flags  (w_flags),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

    assign busy = w_busy;

    // a result only appears right after a busy period ends
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside end of busy period");

    // a taken item makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // divide-by-zero results carry zero payload
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.divide_by_zero) |->
            (o_result.integer_part == '0 && o_result.fraction_part == '0))
        else $error("divide by zero with nonzero result");

    // fraction stays below the scale, or is zero when the scale is zero
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.divide_by_zero) |->
            (64'(o_result.fraction_part) < 64'(r_scale) ||
             (r_scale == '0 && o_result.fraction_part == '0)))
        else $error("fraction not below scale");

endmodule
